### rtl/ptab_pkg.sv
// ----------------------------------------------------------------------------
// Page table engine package
// Shared types, constants and codes for the two-level page table engine.
// ----------------------------------------------------------------------------
package ptab_pkg;

    // Number of directory slots that are built.
    localparam int DIR_SLOTS   = 4;
    localparam int TBL_W       = 10;
    localparam int TBL_ENTRIES = 1 << TBL_W;
    localparam int DIR_SHIFT   = 22;
    localparam int PAGE_SHIFT  = 12;
    localparam int SLOT_W      = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
    localparam int STORE_DEPTH = DIR_SLOTS * TBL_ENTRIES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FULL_W      = SLOT_W + TBL_W;

    // Request kinds.
    localparam logic [2:0] KIND_TRANSLATE = 3'd0;
    localparam logic [2:0] KIND_READ      = 3'd1;
    localparam logic [2:0] KIND_MAP       = 3'd2;
    localparam logic [2:0] KIND_CHANGE    = 3'd3;
    localparam logic [2:0] KIND_UNMAP     = 3'd4;
    localparam logic [2:0] KIND_MAP_ANY   = 3'd5;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_MAPPED = 3'd1,
        ST_ALREADY    = 3'd2,
        ST_NO_FREE    = 3'd3,
        ST_RANGE      = 3'd4
    } t_status;

    // Read address source for the entry store.
    typedef enum logic [1:0] {
        RD_INPUT = 2'd0,
        RD_REQ   = 2'd1,
        RD_SCAN  = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] vaddr;
        logic [31:0] phys_in;
        logic [11:0] flags;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] phys_out;
        logic [31:0] entry_value;
        logic [31:0] found_vaddr;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    clear;
        logic    cnt_inc;
        logic    slot_inc;
        logic    exec;
        logic    scan_hit;
        logic    resp;
        t_status resp_code;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_bad;
        logic in_scan;
        logic in_lookup;
        logic in_present;
        logic req_scan;
        logic slot_present;
        logic entry_free;
        logic cnt_last;
        logic slot_last;
    } t_dp_stat;

endpackage

### rtl/two_level_page_table_engine.sv
// ----------------------------------------------------------------------------
// Two-level page table engine
// A request is taken at a rising edge where start is high and busy is low;
// its result is shown on o_res for exactly one cycle with o_done high, and
// the receiver cannot stall it. Out-of-range requests and lookups in an
// absent directory slot answer in the cycle after the request, with busy
// never raised. Translate, read, map, change-flags and unmap on a present
// slot raise busy: the store read launched from the input address lands in
// the next cycle, where the entry is checked and written back, and a new
// request is taken only after that. The first write-type request to a slot
// clears its 1024-entry table first, one entry per cycle. Map-anywhere
// walks the slots from zero; each absent slot visited is cleared first, and
// each present slot is scanned entry by entry (registered store read, then
// check). There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module two_level_page_table_engine import ptab_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output t_res o_res,
    output logic o_done
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ptab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    ptab_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_res   (o_res),
        .o_done  (o_done)
    );

`ifndef SYNTHESIS
    // A request outside the built range answers at once with out_of_range.
    a_range_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && w_stat.in_bad) |=> (o_done && o_res.status == ST_RANGE))
        else $error("out-of-range request not answered in the next cycle");

    // Every result is shown as the engine returns to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // The engine only becomes busy because a request was taken.
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a request");

    // A found virtual address always comes with a present entry.
    a_found_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.found_vaddr != 32'd0) |-> o_res.entry_value[0])
        else $error("found address without a present entry");
`endif

endmodule

### rtl/ptab_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module ptab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ptab_datapath.sv
// ----------------------------------------------------------------------------
// Page table datapath
// Holds the request, the directory present bits, the walk counters, the
// entry store and the result register.
// ----------------------------------------------------------------------------
module ptab_datapath import ptab_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_req,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_res     o_res,
    output logic     o_done
);

    t_req                 r_req;
    logic [SLOT_W-1:0]    r_slot;
    logic [TBL_W-1:0]     r_cnt;
    logic [DIR_SLOTS-1:0] r_dir_present;
    t_res                 r_res;
    logic                 r_done;

    logic [TBL_W-1:0]  w_in_dir;
    logic [TBL_W-1:0]  w_in_tbl;
    logic [TBL_W-1:0]  w_req_tbl;
    logic              w_in_range;
    logic [FULL_W-1:0] w_raddr_full;
    logic [FULL_W-1:0] w_waddr_full;
    logic              w_we;
    logic [31:0]       w_wdata;
    logic [31:0]       w_rdata;
    logic [31:0]       w_new_entry;
    logic              w_exec_we;
    logic [31:0]       w_exec_wdata;
    t_res              w_exec_res;

    // Decode of the request on the input ports.
    assign w_in_dir   = i_req.vaddr[31:DIR_SHIFT];
    assign w_in_tbl   = i_req.vaddr[DIR_SHIFT-1:PAGE_SHIFT];
    assign w_req_tbl  = r_req.vaddr[DIR_SHIFT-1:PAGE_SHIFT];
    assign w_in_range = ({1'b0, w_in_dir} < (TBL_W + 1)'(DIR_SLOTS));

    assign o_stat.in_scan    = (i_req.kind == KIND_MAP_ANY);
    assign o_stat.in_bad     = (i_req.kind > KIND_MAP_ANY) ||
                               (!o_stat.in_scan && !w_in_range);
    assign o_stat.in_lookup  = (i_req.kind == KIND_TRANSLATE) ||
                               (i_req.kind == KIND_READ);
    assign o_stat.in_present = w_in_range && r_dir_present[w_in_dir[SLOT_W-1:0]];
    assign o_stat.req_scan     = (r_req.kind == KIND_MAP_ANY);
    assign o_stat.slot_present = r_dir_present[r_slot];
    assign o_stat.entry_free   = !w_rdata[0];
    assign o_stat.cnt_last     = (r_cnt == {TBL_W{1'b1}});
    assign o_stat.slot_last    = (r_slot == SLOT_W'(DIR_SLOTS - 1));

    // Entry built from the requested frame and flags, present bit forced on.
    assign w_new_entry = {r_req.phys_in[31:PAGE_SHIFT], r_req.flags[11:1], 1'b1};

    // Single-entry operation on the entry read back from the store.
    always_comb begin
        w_exec_we    = 1'b0;
        w_exec_wdata = 32'd0;
        w_exec_res   = '0;
        w_exec_res.status = ST_OK;
        case (r_req.kind)
            KIND_TRANSLATE, KIND_READ: begin
                if (!w_rdata[0]) begin
                    w_exec_res.status = ST_NOT_MAPPED;
                end else begin
                    w_exec_res.entry_value = w_rdata;
                    if (r_req.kind == KIND_TRANSLATE) begin
                        w_exec_res.phys_out = {w_rdata[31:PAGE_SHIFT],
                                               r_req.vaddr[PAGE_SHIFT-1:0]};
                    end
                end
            end
            KIND_MAP: begin
                if (w_rdata[0]) begin
                    w_exec_res.status      = ST_ALREADY;
                    w_exec_res.entry_value = w_rdata;
                end else begin
                    w_exec_we              = 1'b1;
                    w_exec_wdata           = w_new_entry;
                    w_exec_res.entry_value = w_new_entry;
                end
            end
            KIND_CHANGE: begin
                if (!w_rdata[0]) begin
                    w_exec_res.status = ST_NOT_MAPPED;
                end else begin
                    w_exec_we              = 1'b1;
                    w_exec_wdata           = {w_rdata[31:PAGE_SHIFT], r_req.flags[11:1], 1'b1};
                    w_exec_res.entry_value = w_exec_wdata;
                end
            end
            KIND_UNMAP: begin
                w_exec_we = 1'b1;
            end
            default: begin
                w_exec_res.status = ST_RANGE;
            end
        endcase
    end

    // Store read address.
    always_comb begin
        case (i_cmd.rd_sel)
            RD_REQ:  w_raddr_full = {r_slot, w_req_tbl};
            RD_SCAN: w_raddr_full = {r_slot, r_cnt};
            default: w_raddr_full = {w_in_dir[SLOT_W-1:0], w_in_tbl};
        endcase
    end

    // Store write port: table clear, single-entry write or scan hit.
    always_comb begin
        w_we         = 1'b0;
        w_wdata      = 32'd0;
        w_waddr_full = {r_slot, r_cnt};
        if (i_cmd.clear) begin
            w_we = 1'b1;
        end else if (i_cmd.exec) begin
            w_we         = w_exec_we;
            w_wdata      = w_exec_wdata;
            w_waddr_full = {r_slot, w_req_tbl};
        end else if (i_cmd.scan_hit) begin
            w_we    = 1'b1;
            w_wdata = w_new_entry;
        end
    end

    ptab_ram #(
        .WIDTH (32),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr_full[ADDR_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_full[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Request capture and walk counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req  <= i_req;
            r_slot <= o_stat.in_scan ? '0 : w_in_dir[SLOT_W-1:0];
            r_cnt  <= '0;
        end else begin
            if (i_cmd.clear || i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.slot_inc) begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    // Directory present bits; a slot becomes present while its table clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_present <= '0;
        end else if (i_cmd.clear) begin
            r_dir_present[r_slot] <= 1'b1;
        end
    end

    // Result register and strobe.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res <= w_exec_res;
        end else if (i_cmd.scan_hit) begin
            r_res <= '{status:      ST_OK,
                       phys_out:    32'd0,
                       entry_value: w_new_entry,
                       found_vaddr: {TBL_W'(r_slot), r_cnt, {PAGE_SHIFT{1'b0}}}};
        end else if (i_cmd.resp) begin
            r_res <= '{status:      i_cmd.resp_code,
                       phys_out:    32'd0,
                       entry_value: 32'd0,
                       found_vaddr: 32'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.exec || i_cmd.scan_hit || i_cmd.resp;
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

### rtl/ptab_ctrl.sv
// ----------------------------------------------------------------------------
// Page table controller
// Sequences lookups, single-entry writes, table clears and free-entry scans over the datapath.
// ----------------------------------------------------------------------------
module ptab_ctrl import ptab_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CLEAR    = 7'b0000010,
        S_READ     = 7'b0000100,
        S_EXEC     = 7'b0001000,
        S_SLOT     = 7'b0010000,
        S_SCAN_RD  = 7'b0100000,
        S_SCAN_CHK = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.resp_code = ST_OK;
        o_cmd.rd_sel    = RD_INPUT;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.in_bad) begin
                        o_cmd.resp      = 1'b1;
                        o_cmd.resp_code = ST_RANGE;
                    end else if (i_stat.in_scan) begin
                        n_state = S_SLOT;
                    end else if (i_stat.in_lookup && !i_stat.in_present) begin
                        o_cmd.resp      = 1'b1;
                        o_cmd.resp_code = ST_NOT_MAPPED;
                    end else if (i_stat.in_present) begin
                        // The entry read is already on its way from the input address.
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = i_stat.req_scan ? S_SCAN_RD : S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_sel = RD_REQ;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            S_SLOT: begin
                n_state = i_stat.slot_present ? S_SCAN_RD : S_CLEAR;
            end
            S_SCAN_RD: begin
                o_cmd.rd_sel = RD_SCAN;
                n_state      = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_stat.entry_free) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    if (!i_stat.cnt_last) begin
                        n_state = S_SCAN_RD;
                    end else if (i_stat.slot_last) begin
                        o_cmd.resp      = 1'b1;
                        o_cmd.resp_code = ST_NO_FREE;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.slot_inc = 1'b1;
                        n_state        = S_SLOT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
